>>> hw/rtl/lpm_pkg.sv
// Shared types, constants and helpers for the IPv4 longest-prefix-match table.
package lpm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [5:0] MAX_LEN = 6'd32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ROUTE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_LEN  = 2'd3;

    typedef struct packed {
        logic        op;
        logic [31:0] address;
        logic [5:0]  length;
        logic [31:0] hop_in;
        logic [15:0] port_in;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] hop_out;
        logic [15:0] port_out;
    } out_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
    } key_t;

    typedef struct packed {
        logic [31:0] hop;
        logic [15:0] port;
    } route_t;

    // Top len bits set; zero for len 0 or above 32.
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        m = 32'h0;
        if (len != 6'd0 && len <= MAX_LEN) begin
            m = 32'hFFFF_FFFF << (MAX_LEN - len);
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/ipv4_longest_prefix_match_table.sv
// IPv4 longest-prefix-match routing table, top level.
// An insert or a lookup scans the filled entries (up to 64) in S_SCAN; a found lookup then
// reads its route in S_FETCH; an insert that hits an existing entry stops at it and
// rewrites its route; a bad length goes straight to S_DONE.
// One beat at a time: the next input beat can be taken in the same cycle as the result
// appears, and a stalled result holds the next result in S_DONE.
// Reset clears the fill count and control state; RAM contents are left as they are.
module ipv4_longest_prefix_match_table (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lpm_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lpm_pkg::out_t m_data
);
    import lpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic             op_reg, op_next;
    logic [31:0]      addr_reg, addr_next;
    logic [5:0]       len_reg, len_next;
    logic [31:0]      hop_reg, hop_next;
    logic [15:0]      port_reg, port_next;
    logic [CNT_W-1:0] filled_reg, filled_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic [5:0]       best_len_reg, best_len_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    out_t             res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic             key_wr_en, key_rd_en, rt_wr_en, rt_rd_en;
    logic [IDX_W-1:0] key_wr_addr, key_rd_addr, rt_wr_addr, rt_rd_addr;
    logic [$bits(key_t)-1:0]   key_rd_data;
    logic [$bits(route_t)-1:0] rt_rd_data;
    key_t             entry;
    route_t           route;
    logic             issue;
    logic             key_hit;
    logic             addr_hit;

    lpm_ram #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(key_t))) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_t'({addr_reg, len_reg})),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    lpm_ram #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(route_t))) u_route_ram (
        .aclk    (aclk),
        .wr_en   (rt_wr_en),
        .wr_addr (rt_wr_addr),
        .wr_data (route_t'({hop_reg, port_reg})),
        .rd_en   (rt_rd_en),
        .rd_addr (rt_rd_addr),
        .rd_data (rt_rd_data)
    );

    assign entry    = key_t'(key_rd_data);
    assign route    = route_t'(rt_rd_data);
    assign issue    = (issue_reg < filled_reg);
    assign key_hit  = cmp_valid_reg && (entry.prefix == addr_reg) && (entry.length == len_reg);
    assign addr_hit = cmp_valid_reg && ((addr_reg & prefix_mask(entry.length)) == entry.prefix);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        filled_next    = filled_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_idx_next  = best_idx_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        key_wr_en      = 1'b0;
        key_wr_addr    = filled_reg[IDX_W-1:0];
        key_rd_en      = 1'b0;
        key_rd_addr    = issue_reg[IDX_W-1:0];
        rt_wr_en       = 1'b0;
        rt_wr_addr     = filled_reg[IDX_W-1:0];
        rt_rd_en       = 1'b0;
        rt_rd_addr     = best_idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_data.op;
                    len_next      = s_data.length;
                    hop_next      = s_data.hop_in;
                    port_next     = s_data.port_in;
                    issue_next    = '0;
                    found_next    = 1'b0;
                    best_len_next = '0;
                    res_next      = '{status: ST_OK, hop_out: 32'h0, port_out: 16'h0};
                    if (s_data.op == OP_INSERT) begin
                        addr_next = s_data.address & prefix_mask(s_data.length);
                    end else begin
                        addr_next = s_data.address;
                    end
                    if (s_data.op == OP_INSERT && s_data.length > MAX_LEN) begin
                        res_next.status = ST_BAD_LEN;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    key_rd_en      = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                end
                if (op_reg == OP_INSERT) begin
                    if (key_hit) begin
                        rt_wr_en       = 1'b1;
                        rt_wr_addr     = cmp_idx_reg;
                        cmp_valid_next = 1'b0;
                        state_next     = S_DONE;
                    end else if (!issue && !cmp_valid_reg) begin
                        if (filled_reg == CNT_W'(TABLE_DEPTH)) begin
                            res_next.status = ST_FULL;
                        end else begin
                            key_wr_en   = 1'b1;
                            rt_wr_en    = 1'b1;
                            filled_next = filled_reg + CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                end else begin
                    if (addr_hit && (!found_reg || entry.length > best_len_reg)) begin
                        found_next    = 1'b1;
                        best_len_next = entry.length;
                        best_idx_next = cmp_idx_reg;
                    end
                    if (!issue && !cmp_valid_reg) begin
                        if (found_reg) begin
                            rt_rd_en   = 1'b1;
                            state_next = S_FETCH;
                        end else begin
                            res_next.status = ST_NO_ROUTE;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_FETCH: begin
                res_next.hop_out  = route.hop;
                res_next.port_out = route.port;
                state_next        = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            filled_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        hop_reg      <= hop_next;
        port_reg     <= port_next;
        issue_reg    <= issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        best_len_reg <= best_len_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

>>> hw/rtl/lpm_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module lpm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the IPv4 longest-prefix-match routing table.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpm_pkg::*;

    localparam int N_RANDOM   = 1680;
    localparam int CALM_TAIL  = 200;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 80;

    typedef struct {
        logic        op;
        logic [31:0] address;
        logic [5:0]  length;
        logic [31:0] hop;
        logic [15:0] port;
        bit          known;
        logic [1:0]  status;
    } route_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // routing table as the block should hold it
    logic [31:0] route_prefix [TABLE_DEPTH];
    logic [5:0]  route_len    [TABLE_DEPTH];
    logic [31:0] route_hop    [TABLE_DEPTH];
    logic [15:0] route_port   [TABLE_DEPTH];
    int          route_count = 0;

    out_t expected_routes[$];

    int  error_count  = 0;
    int  idle_cycles  = 0;
    int  ready_hold   = 0;
    bit  bursts_on    = 1'b1;
    int  insert_beats = 0;
    int  lookup_beats = 0;
    int  n_found      = 0;
    int  n_no_route   = 0;
    int  n_full       = 0;
    int  n_bad_len    = 0;

    route_row_t directed_rows[];

    ipv4_longest_prefix_match_table i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [31:0] route_mask(input logic [5:0] len);
        if (len == 6'd0 || len > MAX_LEN) begin
            return 32'h0;
        end
        return ~32'h0 << (32 - int'(len));
    endfunction

    // Update the shadow table with one beat and return the result it should give.
    function automatic out_t apply_route_item(input in_t item);
        out_t        res;
        logic [31:0] masked;
        bit          hit;
        int          best;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        best = 0;
        if (item.op == OP_INSERT) begin
            if (item.length > MAX_LEN) begin
                res.status = ST_BAD_LEN;
            end else begin
                masked = item.address & route_mask(item.length);
                for (int i = 0; i < route_count && !hit; i++) begin
                    if (route_prefix[i] == masked && route_len[i] == item.length) begin
                        route_hop[i]  = item.hop_in;
                        route_port[i] = item.port_in;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    if (route_count >= TABLE_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        route_prefix[route_count] = masked;
                        route_len[route_count]    = item.length;
                        route_hop[route_count]    = item.hop_in;
                        route_port[route_count]   = item.port_in;
                        route_count++;
                    end
                end
            end
        end else begin
            for (int i = 0; i < route_count; i++) begin
                if ((item.address & route_mask(route_len[i])) == route_prefix[i]) begin
                    if (!hit || route_len[i] > route_len[best]) begin
                        hit = 1'b1;
                        best = i;
                    end
                end
            end
            if (hit) begin
                res.hop_out  = route_hop[best];
                res.port_out = route_port[best];
            end else begin
                res.status = ST_NO_ROUTE;
            end
        end
        return res;
    endfunction

    // Mostly inserts and lookups tied to routes already held, some fresh and some bad.
    function automatic in_t random_route_item();
        in_t         item;
        int          r;
        int          pick;
        logic [31:0] m;
        item.op      = 1'($urandom_range(0, 1));
        item.address = $urandom;
        item.length  = 6'($urandom_range(0, 63));
        item.hop_in  = $urandom;
        item.port_in = 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        pick = (route_count > 0) ? $urandom_range(0, route_count - 1) : 0;
        m = route_mask(route_len[pick]);
        if (item.op == OP_INSERT) begin
            if (r < 10) begin
                item.length = 6'($urandom_range(33, 63));
            end else if (r < 35 || route_count == 0) begin
                item.length = 6'($urandom_range(0, 32));
            end else begin
                item.address = route_prefix[pick] | (item.address & ~m);
                if (r < 65) begin
                    item.length = route_len[pick];
                end else begin
                    item.length = 6'($urandom_range(route_len[pick], 32));
                end
            end
        end else if (r < 75 && route_count > 0) begin
            item.address = route_prefix[pick] | (item.address & ~m);
        end
        return item;
    endfunction

    function automatic route_row_t route_row(input logic op, input logic [31:0] address,
                                             input logic [5:0] length, input logic [31:0] hop,
                                             input logic [15:0] port, input bit known,
                                             input logic [1:0] status);
        route_row_t row;
        row.op      = op;
        row.address = address;
        row.length  = length;
        row.hop     = hop;
        row.port    = port;
        row.known   = known;
        row.status  = status;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Drive one beat and record its expected result once accepted.
    task automatic send_beat(input in_t item, input bit known, input logic [1:0] status);
        out_t predicted;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_route_item(item);
        if (known) begin
            predicted = '0;
            predicted.status = status;
        end
        expected_routes.push_back(predicted);
        if (item.op == OP_INSERT) begin
            insert_beats++;
        end else begin
            lookup_beats++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_routes.size() == 0) begin
                report_mismatch("result beat with nothing outstanding",
                                32'(m_data.status), 32'h0);
            end else begin
                want = expected_routes.pop_front();
                if (m_data.status !== want.status) begin
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
                end
                if (m_data.hop_out !== want.hop_out) begin
                    report_mismatch("hop_out", m_data.hop_out, want.hop_out);
                end
                if (m_data.port_out !== want.port_out) begin
                    report_mismatch("port_out", 32'(m_data.port_out), 32'(want.port_out));
                end
                case (want.status)
                    ST_OK:       n_found++;
                    ST_NO_ROUTE: n_no_route++;
                    ST_FULL:     n_full++;
                    default:     n_bad_len++;
                endcase
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            ready_hold = $urandom_range(1, 14) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (idle_cycles < STALL_MAX) @(posedge aclk);
        $display("ERROR: no beat moved for %0d cycles", STALL_MAX);
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        in_t item;
        directed_rows = '{
            route_row(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 16'h0000, 1, ST_NO_ROUTE),
            route_row(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1, ST_NO_ROUTE),
            route_row(OP_INSERT, 32'hFFFF_FFFF, 6'd33, 32'hFFFF_FFFF, 16'hFFFF, 1, ST_BAD_LEN),
            route_row(OP_INSERT, 32'h0A00_0000, 6'd63, 32'h1111_1111, 16'h1111, 1, ST_BAD_LEN),
            route_row(OP_LOOKUP, 32'h0A00_0001, 6'd8,  32'h0000_0000, 16'h0000, 1, ST_NO_ROUTE),
            route_row(OP_INSERT, 32'h0AFF_FFFF, 6'd8,  32'h0A00_0001, 16'h0001, 1, ST_OK),
            route_row(OP_INSERT, 32'h0A01_0203, 6'd16, 32'hC0A8_0001, 16'h0002, 1, ST_OK),
            route_row(OP_INSERT, 32'h0A01_02FF, 6'd24, 32'hFFFF_FFFF, 16'hFFFF, 1, ST_OK),
            route_row(OP_LOOKUP, 32'h0A01_0205, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_LOOKUP, 32'h0A01_0305, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_LOOKUP, 32'h0A02_0000, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_LOOKUP, 32'h0B00_0000, 6'd0,  32'h0000_0000, 16'h0000, 1, ST_NO_ROUTE),
            route_row(OP_INSERT, 32'h0A00_0000, 6'd8,  32'h0000_0000, 16'h0000, 1, ST_OK),
            route_row(OP_LOOKUP, 32'h0A7F_0000, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h1234_5678, 16'h8001, 1, ST_OK),
            route_row(OP_INSERT, 32'h0000_0000, 6'd32, 32'h8765_4321, 16'h7FFE, 1, ST_OK),
            route_row(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_INSERT, 32'h8000_0000, 6'd1,  32'hAAAA_AAAA, 16'hAAAA, 1, ST_OK),
            route_row(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0,  32'h0000_0000, 16'h0000, 1, ST_NO_ROUTE),
            route_row(OP_INSERT, 32'h1234_5678, 6'd0,  32'h5555_5555, 16'h5555, 1, ST_OK),
            route_row(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK),
            route_row(OP_INSERT, 32'h00FF_FFFF, 6'd0,  32'h0000_FFFF, 16'h00FF, 1, ST_OK),
            route_row(OP_LOOKUP, 32'h0B00_0000, 6'd0,  32'h0000_0000, 16'h0000, 0, ST_OK)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k]) begin
            item.op      = directed_rows[k].op;
            item.address = directed_rows[k].address;
            item.length  = directed_rows[k].length;
            item.hop_in  = directed_rows[k].hop;
            item.port_in = directed_rows[k].port;
            send_beat(item, directed_rows[k].known, directed_rows[k].status);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k >= N_RANDOM - CALM_TAIL) begin
                bursts_on = 1'b0;
            end else if (k % 100 == 0) begin
                bursts_on = ($urandom_range(0, 3) != 0);
            end
            send_beat(random_route_item(), 1'b0, ST_OK);
        end
        s_valid <= 1'b0;

        while (expected_routes.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_routes.size() != 0) begin
            report_mismatch("results still outstanding", expected_routes.size(), 0);
        end

        $display("Sent %0d inserts and %0d lookups; table ended with %0d of %0d routes.",
                 insert_beats, lookup_beats, route_count, TABLE_DEPTH);
        $display("Results seen: %0d ok, %0d no route, %0d table full, %0d bad length.",
                 n_found, n_no_route, n_full, n_bad_len);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
